// ===== sv/lpg_pkg.sv =====
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared widths, codes and types of the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 1;
  localparam int POS_BITS   = COORD_BITS + 2;
  localparam int REG_BITS   = COORD_BITS + 1;
  localparam int STEP_BITS  = COORD_BITS + 1;
  localparam int COLOR_BITS = 16;
  localparam int DIR_BITS   = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIR_BITS-1:0] DIR_ZERO = 2'b00;
  localparam logic [DIR_BITS-1:0] DIR_POS  = 2'b01;
  localparam logic [DIR_BITS-1:0] DIR_NEG  = 2'b11;

  localparam logic [REG_BITS-1:0] WIDTH_RESET  = REG_BITS'(240);
  localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(320);

  typedef struct packed {
    logic load;
    logic step;
  } axis_ctrl_t;

endpackage

// ===== sv/lpg_req_if.sv =====
// ----------------------------------------------------------------------------
// lpg_req_if
// Request channel: line load or pixel step.
// ----------------------------------------------------------------------------
interface lpg_req_if;

  logic                                  valid;
  logic                                  ready;
  logic                                  opcode;
  logic [lpg_pkg::COORD_BITS-1:0]        start_x;
  logic [lpg_pkg::COORD_BITS-1:0]        start_y;
  logic [lpg_pkg::COORD_BITS-1:0]        end_x;
  logic [lpg_pkg::COORD_BITS-1:0]        end_y;
  logic [lpg_pkg::COLOR_BITS-1:0]        line_color;

  modport source (
    output valid, opcode, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );

  modport sink (
    input  valid, opcode, start_x, start_y, end_x, end_y, line_color,
    output ready
  );

endinterface

// ===== sv/lpg_pix_if.sv =====
// ----------------------------------------------------------------------------
// lpg_pix_if
// Pixel channel: one rasterized pixel per step request.
// ----------------------------------------------------------------------------
interface lpg_pix_if;

  logic                                  valid;
  logic                                  ready;
  logic signed [lpg_pkg::POS_BITS-1:0]   pixel_x;
  logic signed [lpg_pkg::POS_BITS-1:0]   pixel_y;
  logic [lpg_pkg::COLOR_BITS-1:0]        pixel_color;
  logic                                  visible;
  logic                                  last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, visible, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, visible, last,
    output ready
  );

endinterface

// ===== sv/lpg_axis.sv =====
// ----------------------------------------------------------------------------
// lpg_axis
// One axis of the DDA: delta and sign at load, error accumulate and move
// at each step.
// ----------------------------------------------------------------------------
module lpg_axis (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lpg_pkg::axis_ctrl_t                   ctrl_i,
  input  logic [lpg_pkg::COORD_BITS-1:0]        start_i,
  input  logic [lpg_pkg::COORD_BITS-1:0]        end_i,
  input  logic [lpg_pkg::COORD_BITS-1:0]        major_i,
  output logic [lpg_pkg::COORD_BITS-1:0]        span_new_o,
  output logic signed [lpg_pkg::POS_BITS-1:0]   pos_o
);

  logic [lpg_pkg::COORD_BITS-1:0]       span_q, span_d;
  logic [lpg_pkg::DIR_BITS-1:0]         dir_q, dir_d, dir_new;
  logic [lpg_pkg::ERR_BITS-1:0]         err_q, err_d, err_sum, major_ext;
  logic signed [lpg_pkg::POS_BITS-1:0]  pos_q, pos_d, dir_ext;
  logic                                 move;

  always_comb begin
    if (end_i > start_i) begin
      span_new_o = end_i - start_i;
      dir_new    = lpg_pkg::DIR_POS;
    end else if (end_i == start_i) begin
      span_new_o = '0;
      dir_new    = lpg_pkg::DIR_ZERO;
    end else begin
      span_new_o = start_i - end_i;
      dir_new    = lpg_pkg::DIR_NEG;
    end
  end

  assign major_ext = {1'b0, major_i};
  assign err_sum   = err_q + {1'b0, span_q};
  assign move      = err_sum > major_ext;
  assign dir_ext   = {{(lpg_pkg::POS_BITS-lpg_pkg::DIR_BITS){dir_q[1]}}, dir_q};

  always_comb begin
    span_d = span_q;
    dir_d  = dir_q;
    err_d  = err_q;
    pos_d  = pos_q;
    if (ctrl_i.load) begin
      span_d = span_new_o;
      dir_d  = dir_new;
      err_d  = '0;
      pos_d  = {{(lpg_pkg::POS_BITS-lpg_pkg::COORD_BITS){1'b0}}, start_i};
    end else if (ctrl_i.step) begin
      err_d = move ? err_sum - major_ext : err_sum;
      pos_d = move ? pos_q + dir_ext : pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0;
      dir_q  <= lpg_pkg::DIR_ZERO;
      err_q  <= '0;
      pos_q  <= '0;
    end else begin
      span_q <= span_d;
      dir_q  <= dir_d;
      err_q  <= err_d;
      pos_q  <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== sv/line_pixel_generator_top.sv =====
// ----------------------------------------------------------------------------
// line_pixel_generator_top
// Integer DDA line rasterizer streaming one clipped pixel per step request.
//
//   channel   dir  kind           payload
//   req_i     in   valid/ready    opcode, start_x/y, end_x/y, line_color
//   pix_o     out  valid/ready    pixel_x/y, pixel_color, visible, last
//   cfg       in   write strobe   cfg_we_i, cfg_index_i, cfg_data_i
//
// One request per cycle unless a pixel waits unread in the output register;
// a step request yields its pixel in the next cycle from the output register,
// limited only by the per-axis add and compare. A load yields nothing;
// a step with no active line is dropped. req_i.ready is low only while a
// pixel waits unread in the output register. Reset clears the line state
// and restores screen size 240 x 320.
// ----------------------------------------------------------------------------
module line_pixel_generator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [lpg_pkg::REG_BITS-1:0]      cfg_data_i,
  lpg_req_if.sink                           req_i,
  lpg_pix_if.source                         pix_o
);

  logic [lpg_pkg::REG_BITS-1:0]        width_q, width_d;
  logic [lpg_pkg::REG_BITS-1:0]        height_q, height_d;
  logic [lpg_pkg::COORD_BITS-1:0]      major_q, major_d;
  logic [lpg_pkg::STEP_BITS-1:0]       steps_q, steps_d;
  logic [lpg_pkg::COLOR_BITS-1:0]      color_q, color_d;
  logic                                busy_q, busy_d;
  logic                                out_valid_q, out_valid_d;
  logic signed [lpg_pkg::POS_BITS-1:0] px_q, py_q;
  logic [lpg_pkg::COLOR_BITS-1:0]      pcolor_q;
  logic                                vis_q, last_q;

  logic [lpg_pkg::COORD_BITS-1:0]      span_new_x, span_new_y, major_new;
  logic signed [lpg_pkg::POS_BITS-1:0] cur_x, cur_y;
  lpg_pkg::axis_ctrl_t                 axis_ctrl;
  logic                                accept, load_go, step_go, fin, vis;

  assign req_i.ready = !out_valid_q || pix_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign load_go     = accept && (req_i.opcode == lpg_pkg::OP_LOAD);
  assign step_go     = accept && (req_i.opcode == lpg_pkg::OP_STEP) && busy_q;

  assign axis_ctrl.load = load_go;
  assign axis_ctrl.step = step_go;

  lpg_axis u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (axis_ctrl),
    .start_i    (req_i.start_x),
    .end_i      (req_i.end_x),
    .major_i    (major_q),
    .span_new_o (span_new_x),
    .pos_o      (cur_x)
  );

  lpg_axis u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (axis_ctrl),
    .start_i    (req_i.start_y),
    .end_i      (req_i.end_y),
    .major_i    (major_q),
    .span_new_o (span_new_y),
    .pos_o      (cur_y)
  );

  assign major_new = (span_new_x > span_new_y) ? span_new_x : span_new_y;
  assign fin       = steps_q <= lpg_pkg::STEP_BITS'(1);
  assign vis       = !cur_x[lpg_pkg::POS_BITS-1] && !cur_y[lpg_pkg::POS_BITS-1] &&
                     (cur_x[lpg_pkg::REG_BITS-1:0] < width_q) &&
                     (cur_y[lpg_pkg::REG_BITS-1:0] < height_q);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        lpg_pkg::REG_WIDTH:  width_d  = cfg_data_i;
        lpg_pkg::REG_HEIGHT: height_d = cfg_data_i;
        default:             width_d  = width_q;
      endcase
    end
  end

  always_comb begin
    major_d     = major_q;
    steps_d     = steps_q;
    color_d     = color_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !pix_o.ready;
    if (load_go) begin
      major_d = major_new;
      steps_d = lpg_pkg::STEP_BITS'(major_new) + lpg_pkg::STEP_BITS'(2);
      color_d = req_i.line_color;
      busy_d  = 1'b1;
    end else if (step_go) begin
      steps_d = fin ? '0 : steps_q - lpg_pkg::STEP_BITS'(1);
      busy_d  = !fin;
    end
    if (step_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= lpg_pkg::WIDTH_RESET;
      height_q    <= lpg_pkg::HEIGHT_RESET;
      major_q     <= '0;
      steps_q     <= '0;
      color_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      major_q     <= major_d;
      steps_q     <= steps_d;
      color_q     <= color_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      px_q     <= cur_x;
      py_q     <= cur_y;
      pcolor_q <= color_q;
      vis_q    <= vis;
      last_q   <= fin;
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_x     = px_q;
  assign pix_o.pixel_y     = py_q;
  assign pix_o.pixel_color = pcolor_q;
  assign pix_o.visible     = vis_q;
  assign pix_o.last        = last_q;

`ifndef SYNTHESIS
  a_busy_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (steps_q != '0))
    else $error("busy flag and step count disagree");

  a_step_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go |=> out_valid_q)
    else $error("accepted step produced no pixel");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_go && fin) |=> !busy_q && last_q)
    else $error("final pixel did not end the line");

  a_load_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_go |=> busy_q && (steps_q >= lpg_pkg::STEP_BITS'(2)))
    else $error("load did not arm a full line");
`endif

endmodule
